// ===== hw/rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Ring geometry, command and status codes, and the structs between modules.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Ring depth. Must be a power of two so ring positions wrap by truncation.
  localparam int DEPTH   = 16;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int ENTRY_W = 5;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_OUT  = 1'b1
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr_front;
    logic [ADDR_W-1:0] raddr_back;
  } mem_req_t;

  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] count;
    status_t          status;
  } deq_stat_t;

endpackage

// ===== hw/rtl/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram: ring storage
// One write port and two registered read ports; a read of the entry being
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module deq_ram (
  input  logic                  clk,
  input  deq_pkg::mem_req_t     req,
  output logic [deq_pkg::DATA_W-1:0] rdata_front,
  output logic [deq_pkg::DATA_W-1:0] rdata_back
);
  import deq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we && (req.waddr == req.raddr_front)) begin
      rdata_front <= req.wdata;
    end else begin
      rdata_front <= mem[req.raddr_front];
    end
    if (req.we && (req.waddr == req.raddr_back)) begin
      rdata_back <= req.wdata;
    end else begin
      rdata_back <= mem[req.raddr_back];
    end
  end

endmodule

// ===== hw/rtl/deq_ptr.sv =====
// ----------------------------------------------------------------------------
// deq_ptr: pointer control for the double-ended queue
// Holds the front position and entry count, decodes commands, issues the
// ring write and the two reads that fetch the new front and back entries.
// ----------------------------------------------------------------------------
module deq_ptr (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  deq_pkg::cmd_t                 cmd,
  input  logic [deq_pkg::DATA_W-1:0]    value,
  input  logic                          out_free,
  output deq_pkg::mem_req_t             req,
  output deq_pkg::deq_stat_t            stat
);
  import deq_pkg::*;

  state_t             state, state_next;
  logic [ADDR_W-1:0]  front, front_next;
  logic [CNT_W-1:0]   count, count_next;
  status_t            status, status_next;
  logic               is_full_now, is_empty_now;

  assign is_full_now  = (count == CNT_W'(DEPTH));
  assign is_empty_now = (count == '0);

  always_comb begin
    front_next  = front;
    count_next  = count;
    status_next = status;
    state_next  = state;
    in_ready    = 1'b0;
    stat.load   = 1'b0;
    stat.count  = count;
    stat.status = status;
    req.we      = 1'b0;
    req.waddr   = front;
    req.wdata   = value;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next  = S_OUT;
          status_next = ST_OK;
          case (cmd)
            CMD_PUSH_FRONT: begin
              if (is_full_now) begin
                status_next = ST_PUSH_FULL;
              end else begin
                front_next = front - ADDR_W'(1);
                req.we     = 1'b1;
                req.waddr  = front - ADDR_W'(1);
                count_next = count + CNT_W'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (is_full_now) begin
                status_next = ST_PUSH_FULL;
              end else begin
                req.we     = 1'b1;
                req.waddr  = front + count[ADDR_W-1:0];
                count_next = count + CNT_W'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (is_empty_now) begin
                status_next = ST_POP_EMPTY;
              end else begin
                front_next = front + ADDR_W'(1);
                count_next = count - CNT_W'(1);
              end
            end
            default: begin
              if (is_empty_now) begin
                status_next = ST_POP_EMPTY;
              end else begin
                count_next = count - CNT_W'(1);
              end
            end
          endcase
        end
      end
      S_OUT: begin
        if (out_free) begin
          stat.load  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // Reads are issued for the state after the command; unused when empty.
    req.raddr_front = front_next;
    req.raddr_back  = front_next + count_next[ADDR_W-1:0] - ADDR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      front  <= '0;
      count  <= '0;
      status <= ST_OK;
    end else begin
      state  <= state_next;
      front  <= front_next;
      count  <= count_next;
      status <= status_next;
    end
  end

endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue of signed 32-bit values
// Ring buffer of DEPTH entries with push and pop at both ends; each command
// returns the front and back values, entry count, flags and a status code.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Fields (lowest bit first)
// s_*       in   tuser: command[1:0]; tdata: value[31:0]
// m_*       out  tdata: front_value[31:0], back_value[63:32],
//                entry_count[68:64], is_empty[69], is_full[70],
//                status[72:71], zero fill[79:73]
//
// For each command, the transfer cycle updates the pointers and writes the
// ring, and the next cycle receives the registered read data for the new
// front and back entries; the next command is accepted once that result is
// loaded. The output register holds one finished result; a stalled output
// lets the next command be accepted, and the block then waits with s_tready
// low until that result is taken. Reset clears the pointers and count; the
// ring contents need no clearing since only stored entries are read.
//
module double_ended_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // front, back, count, empty, full, status
);
  import deq_pkg::*;

  mem_req_t          req;
  deq_stat_t         stat;
  logic [DATA_W-1:0] rd_front, rd_back;
  logic              out_free;
  logic              empty_now, full_now;

  // The output register can take a new result when empty or being drained.
  assign out_free = !m_tvalid || m_tready;

  deq_ptr u_ptr (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd_t'(s_tuser)),
    .value    (s_tdata),
    .out_free (out_free),
    .req      (req),
    .stat     (stat)
  );

  deq_ram u_ram (
    .clk         (clk),
    .req         (req),
    .rdata_front (rd_front),
    .rdata_back  (rd_back)
  );

  assign empty_now = (stat.count == '0);
  assign full_now  = (stat.count == CNT_W'(DEPTH));

  // Result register. An empty deque reports zero for both end values.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (stat.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.load) begin
      m_tdata[31:0]  <= empty_now ? '0 : rd_front;
      m_tdata[63:32] <= empty_now ? '0 : rd_back;
      m_tdata[68:64] <= ENTRY_W'(stat.count);
      m_tdata[69]    <= empty_now;
      m_tdata[70]    <= full_now;
      m_tdata[72:71] <= stat.status;
      m_tdata[79:73] <= '0;
    end
  end

  // The entry count never exceeds the ring depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= CNT_W'(DEPTH))
    else $error("entry count above ring depth");

  // A pop on an empty deque leaves the count at zero.
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser[1] && (stat.count == '0))
      |=> (stat.count == '0) && (stat.status == ST_POP_EMPTY))
    else $error("pop on empty changed state");

  // A push on a full deque is dropped and reported.
  a_push_full: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser[1] && (stat.count == CNT_W'(DEPTH)))
      |=> (stat.count == CNT_W'(DEPTH)) && (stat.status == ST_PUSH_FULL))
    else $error("push on full changed state");

  // A result is loaded only into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    stat.load |-> (!m_tvalid || m_tready))
    else $error("result overwrote a pending output");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the double-ended queue
// Drives push and pop commands over the input stream and checks every result
// on the output stream against a ring model kept inside the testbench.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  // Run length and pacing.
  localparam int RANDOM_ITEMS = 1925;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam int REPORT_CAP   = 40;

  // One result as the block reports it.
  typedef struct packed {
    logic [6:0]         fill;
    status_t            status;
    logic               is_full;
    logic               is_empty;
    logic [ENTRY_W-1:0] entry_count;
    logic [DATA_W-1:0]  back_value;
    logic [DATA_W-1:0]  front_value;
  } deque_view_t;

  // Ring model of the deque plus the queue of views that are still owed by
  // the block. Every accepted command adds one view; every result takes one.
  class deque_tracker;
    logic [DATA_W-1:0] ring [DEPTH];
    logic [ADDR_W-1:0] front_pos;
    int unsigned       count;
    deque_view_t       pending_views [$];
    int                errors;
    int                reported;

    function new();
      foreach (ring[i]) ring[i] = '0;
      front_pos = '0;
      count     = 0;
      errors    = 0;
      reported  = 0;
    endfunction

    function void note_command(cmd_t cmd, logic [DATA_W-1:0] value);
      deque_view_t       view;
      logic [ADDR_W-1:0] pos;
      view        = '0;
      view.status = ST_OK;
      case (cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (count >= DEPTH) begin
            view.status = ST_PUSH_FULL;
          end else if (cmd == CMD_PUSH_FRONT) begin
            front_pos       = front_pos - 1'b1;
            ring[front_pos] = value;
            count++;
          end else begin
            pos       = ADDR_W'(front_pos + count);
            ring[pos] = value;
            count++;
          end
        end
        default: begin
          if (count == 0) begin
            view.status = ST_POP_EMPTY;
          end else if (cmd == CMD_POP_FRONT) begin
            front_pos = front_pos + 1'b1;
            count--;
          end else begin
            count--;
          end
        end
      endcase
      if (count != 0) begin
        view.front_value = ring[front_pos];
        pos              = ADDR_W'(front_pos + count - 1);
        view.back_value  = ring[pos];
      end
      view.entry_count = count[ENTRY_W-1:0];
      view.is_empty    = (count == 0);
      view.is_full     = (count == DEPTH);
      pending_views.push_back(view);
    endfunction

    function void report(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      errors++;
      if (reported < REPORT_CAP) begin
        reported++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [79:0] raw);
      deque_view_t got;
      deque_view_t want;
      got = raw;
      if (pending_views.size() == 0) begin
        errors++;
        if (reported < REPORT_CAP) begin
          reported++;
          $display("%0t: unexpected result: expected none, actual %h", $time, raw);
        end
        return;
      end
      want = pending_views.pop_front();
      if (got.front_value !== want.front_value)
        report("front_value", want.front_value, got.front_value);
      if (got.back_value !== want.back_value)
        report("back_value", want.back_value, got.back_value);
      if (got.entry_count !== want.entry_count)
        report("entry_count", DATA_W'(want.entry_count), DATA_W'(got.entry_count));
      if (got.is_empty !== want.is_empty)
        report("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
      if (got.is_full !== want.is_full)
        report("is_full", DATA_W'(want.is_full), DATA_W'(got.is_full));
      if (got.status !== want.status)
        report("status", DATA_W'(want.status), DATA_W'(got.status));
      if (got.fill !== want.fill)
        report("zero fill", DATA_W'(want.fill), DATA_W'(got.fill));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // value[31:0]
  logic [1:0]  s_tuser;   // command[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;   // front, back, count, empty, full, status, zero fill

  deque_tracker tracker;
  int unsigned  accepted_cmds;
  int unsigned  cycle_count;
  int           burst_left;

  double_ended_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both monitors sample at the rising edge, before any nonblocking update of
  // that edge lands, so every transfer is seen with the values it carried.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      tracker.note_command(cmd_t'(s_tuser), s_tdata);
      accepted_cmds++;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      tracker.check_result(m_tdata);
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Picks a push value, now and then one of the extremes of the range.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Offers one command and returns once it has been transferred. The sender
  // works in bursts: when a burst runs out, valid drops for a random gap,
  // which may be zero so that some bursts run back to back.
  task automatic send_command(cmd_t cmd, logic [DATA_W-1:0] value);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        s_tdata  <= $urandom;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Short directed sequence: pops on an empty deque, a single entry seen from
  // both ends, a fill to the brim through both ends with the extreme values,
  // and pushes at both ends of a full deque.
  task automatic run_directed();
    logic [DATA_W-1:0] v;
    send_command(CMD_POP_FRONT, 32'hffff_ffff);
    send_command(CMD_POP_BACK, 32'h0000_0000);
    send_command(CMD_PUSH_FRONT, 32'h8000_0000);
    send_command(CMD_POP_BACK, $urandom);
    send_command(CMD_PUSH_BACK, 32'h7fff_ffff);
    send_command(CMD_POP_FRONT, $urandom);
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0:       v = 32'h8000_0000;
        1:       v = 32'h7fff_ffff;
        2:       v = (i == 2) ? 32'h0000_0000 : 32'hffff_ffff;
        default: v = $urandom;
      endcase
      send_command(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, v);
    end
    send_command(CMD_PUSH_FRONT, $urandom);
    send_command(CMD_PUSH_BACK, $urandom);
  endtask

  // Random part. Commands come in phases with a push bias, so the deque
  // drifts between empty and full and spends time at both boundaries, with
  // the front position wrapping around the ring many times.
  task automatic run_random();
    int   phase_left;
    int   push_bias;
    cmd_t cmd;
    phase_left = 0;
    push_bias  = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(15, 60);
        case ($urandom_range(0, 2))
          0:       push_bias = 85;
          1:       push_bias = 50;
          default: push_bias = 15;
        endcase
      end
      phase_left--;
      if ($urandom_range(0, 99) < push_bias)
        cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      else
        cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
      send_command(cmd, pick_value());
    end
  endtask

  // Receiver: stalls on patterns of its own, one stretch at a time. Once,
  // after a few hundred commands, it holds off for a long stretch while the
  // sender keeps offering, so the block fills up and backs up its input.
  initial begin
    int  mode;
    int  span;
    bit  held;
    held = 1'b0;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && accepted_cmds >= HOLD_AFTER) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          m_tready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= $urandom_range(0, 1);
          2:       m_tready <= ($urandom_range(0, 7) == 0);
          default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Main sequence: reset, directed commands, random commands, then drain.
  initial begin
    tracker       = new();
    accepted_cmds = 0;
    cycle_count   = 0;
    burst_left    = $urandom_range(1, 40);
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= CMD_PUSH_FRONT;
    s_tdata  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_random();
    s_tvalid <= 1'b0;

    // Let the monitor note the last transfer before counting what is owed.
    @(posedge clk);

    // Wait for every owed result, then keep watching for stray results.
    while (tracker.pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending_views.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
